### design/c2dv_pkg.sv
// Shared types, constants and register codes for the 2-D valid correlation block.
package c2dv_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W = 16;
  localparam int VALUE_W  = 40;
  localparam int ROW_W    = 12;
  localparam int OCOL_W   = 10;
  localparam int COL_W    = 12;
  localparam int IDX_W    = 6;
  localparam int CFG_W    = 13;

  // Kernel store is addressed as row times KSIDE plus column.
  localparam int KSIDE          = 8;
  localparam int MAX_IMAGE_ROWS = 4096;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_IMAGE_COLS  = 1024;
  localparam int DEF_MAX_KERNEL_ROWS = 8;
  localparam int DEF_MAX_KERNEL_COLS = 8;

  // Depth of the queue between the front and back parts.
  localparam int QDEPTH = 4;

  typedef enum logic [1:0] {
    REG_IMAGE_ROWS  = 2'd0,
    REG_IMAGE_COLS  = 2'd1,
    REG_KERNEL_ROWS = 2'd2,
    REG_KERNEL_COLS = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    CMD_COEF   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_e;

  // Effective (clamped) configuration.
  typedef struct packed {
    logic [12:0] rows;
    logic [12:0] cols;
    logic [3:0]  krows;
    logic [3:0]  kcols;
  } cfg_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    logic                       is_sample;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] sample;
    logic [COL_W-1:0]           col;
    logic                       emit;
    logic                       last;
    logic [ROW_W-1:0]           wr;
    logic [OCOL_W-1:0]          wc;
  } item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### design/c2dv_front.sv
// Front part: configuration registers, frame counters and item classification.
module c2dv_front import c2dv_pkg::*; #(
  parameter int MAX_IMAGE_COLS  = DEF_MAX_IMAGE_COLS,
  parameter int MAX_KERNEL_ROWS = DEF_MAX_KERNEL_ROWS,
  parameter int MAX_KERNEL_COLS = DEF_MAX_KERNEL_COLS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_idx_i,
  input  logic [CFG_W-1:0]           cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic                       cmd_i,
  input  logic [IDX_W-1:0]           coef_index_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       push_o,
  output item_t                      item_o,
  output cfg_t                       cfg_o
);

  localparam int KR_L = (MAX_KERNEL_ROWS < KSIDE) ? MAX_KERNEL_ROWS : KSIDE;
  localparam int KC_L = (MAX_KERNEL_COLS < KSIDE) ? MAX_KERNEL_COLS : KSIDE;

  logic [12:0]      img_rows_q;
  logic [10:0]      img_cols_q;
  logic [3:0]       ker_rows_q, ker_cols_q;
  logic [12:0]      rows_eff, cols_eff, cols_raw;
  logic [3:0]       kr_eff, kc_eff;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic             accept, smp, row_end, frame_end;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_rows_q <= 13'd8;
      img_cols_q <= 11'd8;
      ker_rows_q <= 4'd3;
      ker_cols_q <= 4'd3;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_IMAGE_ROWS:  img_rows_q <= cfg_wdata_i;
        REG_IMAGE_COLS:  img_cols_q <= cfg_wdata_i[10:0];
        REG_KERNEL_ROWS: ker_rows_q <= cfg_wdata_i[3:0];
        REG_KERNEL_COLS: ker_cols_q <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  // Clamp the registers to their usable ranges.
  always_comb begin
    cols_raw = 13'(img_cols_q);
    if (img_rows_q == 13'd0) rows_eff = 13'd1;
    else if (img_rows_q > 13'(MAX_IMAGE_ROWS)) rows_eff = 13'(MAX_IMAGE_ROWS);
    else rows_eff = img_rows_q;
    if (cols_raw == 13'd0) cols_eff = 13'd1;
    else if (cols_raw > 13'(MAX_IMAGE_COLS)) cols_eff = 13'(MAX_IMAGE_COLS);
    else cols_eff = cols_raw;
    if (ker_rows_q == 4'd0) kr_eff = 4'd1;
    else if (ker_rows_q > 4'(KR_L)) kr_eff = 4'(KR_L);
    else kr_eff = ker_rows_q;
    if (ker_cols_q == 4'd0) kc_eff = 4'd1;
    else if (ker_cols_q > 4'(KC_L)) kc_eff = 4'(KC_L);
    else kc_eff = ker_cols_q;
  end

  assign cfg_o = '{rows: rows_eff, cols: cols_eff, krows: kr_eff, kcols: kc_eff};

  assign accept    = in_valid_i && in_ready_i;
  assign smp       = accept && (cmd_e'(cmd_i) == CMD_SAMPLE);
  assign row_end   = (13'(col_q) + 13'd1) == cols_eff;
  assign frame_end = (13'(row_q) + 13'd1) == rows_eff;

  // Raster position of the next sample.
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cfg_we_i) begin
      row_d = '0;
      col_d = '0;
    end else if (smp) begin
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // Classify the item and work out its window position.
  always_comb begin
    item_o.is_sample = (cmd_e'(cmd_i) == CMD_SAMPLE);
    item_o.idx       = coef_index_i;
    item_o.sample    = sample_i;
    item_o.col       = col_q;
    item_o.emit      = ((13'(row_q) + 13'd1) >= 13'(kr_eff)) &&
                       ((13'(col_q) + 13'd1) >= 13'(kc_eff));
    item_o.last      = row_end && frame_end;
    item_o.wr        = row_q + ROW_W'(1) - ROW_W'(kr_eff);
    item_o.wc        = OCOL_W'(col_q + COL_W'(1) - COL_W'(kc_eff));
  end

  assign push_o = accept;

endmodule

### design/c2dv_queue.sv
// Short queue of classified items between the front and back parts.
module c2dv_queue import c2dv_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  item_t   item_i,
  input  logic    pop_i,
  output item_t   item_o,
  output q_stat_t stat_o
);

  localparam int PW = $clog2(QDEPTH);

  item_t         buf_q [QDEPTH];
  logic [PW-1:0] wptr_q, rptr_q;
  logic [PW:0]   cnt_q;

  assign stat_o.full  = cnt_q == (PW+1)'(QDEPTH);
  assign stat_o.empty = cnt_q == '0;
  assign item_o       = buf_q[rptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) buf_q[wptr_q] <= item_i;
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + PW'(1);
      if (pop_i)  rptr_q <= rptr_q + PW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + (PW+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PW+1)'(1);
        default: ;
      endcase
    end
  end

endmodule

### design/c2dv_back.sv
// Back part: line memory, window registers, multiplier lanes, adder tree, output register.
module c2dv_back import c2dv_pkg::*; #(
  parameter int MAX_IMAGE_COLS  = DEF_MAX_IMAGE_COLS,
  parameter int MAX_KERNEL_ROWS = DEF_MAX_KERNEL_ROWS,
  parameter int MAX_KERNEL_COLS = DEF_MAX_KERNEL_COLS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  item_t                     q_item_i,
  input  q_stat_t                   q_stat_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic [ROW_W-1:0]          out_row_o,
  output logic [OCOL_W-1:0]         out_col_o,
  output logic                      last_o
);

  localparam int KR_L = (MAX_KERNEL_ROWS < KSIDE) ? MAX_KERNEL_ROWS : KSIDE;
  localparam int KC_L = (MAX_KERNEL_COLS < KSIDE) ? MAX_KERNEL_COLS : KSIDE;
  localparam int AW   = $clog2(MAX_IMAGE_COLS);

  typedef logic [KR_L-1:0][SAMPLE_W-1:0] colw_t;

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  item_t it1_q, it2_q, it3_q, it4_q, it5_q;

  colw_t mem [MAX_IMAGE_COLS];
  colw_t rd_q, fwd_word_q, old_word, new_word;
  logic [AW-1:0] fwd_col_q;
  logic          fwd_v_q;

  logic signed [SAMPLE_W-1:0]  win_q  [KR_L][KC_L];
  logic signed [SAMPLE_W-1:0]  pix_d  [KR_L][KC_L];
  logic signed [SAMPLE_W-1:0]  pix_q  [KR_L][KC_L];
  logic signed [SAMPLE_W-1:0]  kern_q [KR_L][KC_L];
  logic signed [2*SAMPLE_W-1:0] prod_q [KR_L][KC_L];
  logic signed [VALUE_W-1:0]   rsum_d [KR_L];
  logic signed [VALUE_W-1:0]   rsum_q [KR_L];
  logic signed [VALUE_W-1:0]   total;

  logic out_valid_q;

  // The whole back pipeline moves together unless a result waits for the receiver.
  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && !q_stat_i.empty;

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= pop_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (en) begin
      it1_q <= q_item_i;
      it2_q <= it1_q;
      it3_q <= it2_q;
      it4_q <= it3_q;
      it5_q <= it4_q;
    end
  end

  // Column word: the stored older rows at this column, forwarded from the last
  // write when that write went to the same column.
  always_comb begin
    old_word = (fwd_v_q && fwd_col_q == it1_q.col[AW-1:0]) ? fwd_word_q : rd_q;
    for (int a = 0; a < KR_L; a++) begin
      if (a == 0) new_word[a] = it1_q.sample;
      else        new_word[a] = old_word[a-1];
    end
  end

  // Line memory: read on pop, write back the shifted column one stage later.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (pop_o && q_item_i.is_sample) rd_q <= mem[q_item_i.col[AW-1:0]];
      if (v1_q && it1_q.is_sample) begin
        mem[it1_q.col[AW-1:0]] <= new_word;
        fwd_col_q              <= it1_q.col[AW-1:0];
        fwd_word_q             <= new_word;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) fwd_v_q <= 1'b0;
    else if (en && v1_q && it1_q.is_sample) fwd_v_q <= 1'b1;
  end

  // Window registers: newest column enters at age zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < KR_L; a++) begin
        for (int b = 0; b < KC_L; b++) win_q[a][b] <= '0;
      end
    end else if (en && v1_q && it1_q.is_sample) begin
      for (int a = 0; a < KR_L; a++) begin
        win_q[a][0] <= new_word[a];
        for (int b = 1; b < KC_L; b++) win_q[a][b] <= win_q[a][b-1];
      end
    end
  end

  // Route window samples to the kernel lanes; lanes outside the kernel get zero.
  always_comb begin
    int ki, kj;
    ki = int'(cfg_i.krows);
    kj = int'(cfg_i.kcols);
    for (int i = 0; i < KR_L; i++) begin
      for (int j = 0; j < KC_L; j++) begin
        pix_d[i][j] = '0;
        for (int a = 0; a < KR_L; a++) begin
          for (int b = 0; b < KC_L; b++) begin
            if (i < ki && j < kj && a == ki - 1 - i && b == kj - 1 - j) begin
              pix_d[i][j] = win_q[a][b];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) pix_q <= pix_d;
  end

  // Kernel coefficients are written in order with the samples, at the multiply stage.
  always_ff @(posedge clk_i) begin
    if (en && v3_q && !it3_q.is_sample) begin
      for (int i = 0; i < KR_L; i++) begin
        for (int j = 0; j < KC_L; j++) begin
          if (int'(it3_q.idx[5:3]) == i && int'(it3_q.idx[2:0]) == j) begin
            kern_q[i][j] <= it3_q.sample;
          end
        end
      end
    end
  end

  // One multiplier per lane.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < KR_L; i++) begin
        for (int j = 0; j < KC_L; j++) prod_q[i][j] <= pix_q[i][j] * kern_q[i][j];
      end
    end
  end

  // Adder tree: row sums, then the total.
  always_comb begin
    for (int i = 0; i < KR_L; i++) begin
      rsum_d[i] = '0;
      for (int j = 0; j < KC_L; j++) rsum_d[i] = rsum_d[i] + VALUE_W'(prod_q[i][j]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) rsum_q <= rsum_d;
  end

  always_comb begin
    total = '0;
    for (int i = 0; i < KR_L; i++) total = total + rsum_q[i];
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= v5_q && it5_q.is_sample && it5_q.emit;
  end

  always_ff @(posedge clk_i) begin
    if (en && v5_q && it5_q.is_sample && it5_q.emit) begin
      out_value_o <= total;
      out_row_o   <= it5_q.wr;
      out_col_o   <= it5_q.wc;
      last_o      <= it5_q.last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### design/conv2d_valid_correlation.sv
// Top level of the 2-D valid-region cross-correlation block.
// Usage: write image_rows, image_cols, kernel_rows and kernel_cols through the
// configuration port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while the block is idle;
// each write restarts the frame. Then send coefficient transfers (cmd_i low,
// coef_index_i = row*8+col) followed by image samples in raster order (cmd_i high).
// Every sample that completes a window yields one result transfer carrying the
// exact window sum, the window's top-left position and a last flag on the final
// window of the frame.
// Throughput: one input transfer per cycle while the queue is not full. The
// queue hands the item on together with the line-memory read, then window shift,
// lane select, multiply, row sums and the output register, which raises
// out_valid_o.
// Reset clears the counters, queue, pipeline valid flags and window registers
// and restores the register defaults (8x8 image, 3x3 kernel); the kernel and
// line memories are not cleared. When the receiver holds out_ready_i low the
// back pipeline stops and the four-entry queue absorbs input before
// in_ready_o falls.
module conv2d_valid_correlation import c2dv_pkg::*; #(
  parameter int MAX_IMAGE_COLS  = DEF_MAX_IMAGE_COLS,
  parameter int MAX_KERNEL_ROWS = DEF_MAX_KERNEL_ROWS,
  parameter int MAX_KERNEL_COLS = DEF_MAX_KERNEL_COLS
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [CFG_W-1:0]          cfg_wdata_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      cmd_i,
  input  logic [IDX_W-1:0]          coef_index_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [VALUE_W-1:0] out_value_o,
  output logic [ROW_W-1:0]          out_row_o,
  output logic [OCOL_W-1:0]         out_col_o,
  output logic                      last_o
);

  logic    push, pop;
  item_t   f_item, q_item;
  cfg_t    cfg;
  q_stat_t q_stat;

  assign in_ready_o = !q_stat.full;

  // Front: counters and classification.
  c2dv_front #(
    .MAX_IMAGE_COLS (MAX_IMAGE_COLS),
    .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS(MAX_KERNEL_COLS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .cmd_i       (cmd_i),
    .coef_index_i(coef_index_i),
    .sample_i    (sample_i),
    .push_o      (push),
    .item_o      (f_item),
    .cfg_o       (cfg)
  );

  // Queue between the two parts.
  c2dv_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .item_i(f_item),
    .pop_i (pop),
    .item_o(q_item),
    .stat_o(q_stat)
  );

  // Back: line memory, window and arithmetic.
  c2dv_back #(
    .MAX_IMAGE_COLS (MAX_IMAGE_COLS),
    .MAX_KERNEL_ROWS(MAX_KERNEL_ROWS),
    .MAX_KERNEL_COLS(MAX_KERNEL_COLS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_item_i   (q_item),
    .q_stat_i   (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_value_o(out_value_o),
    .out_row_o  (out_row_o),
    .out_col_o  (out_col_o),
    .last_o     (last_o)
  );

  // The queue is never both full and empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(q_stat.full && q_stat.empty))
    else $error("queue reports full and empty together");

  // Nothing is taken from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // The last window of a frame sits at the right-hand edge of the image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> out_col_o == OCOL_W'(cfg.cols - 13'(cfg.kcols)))
    else $error("last result not at the final window column");

endmodule
